// File: src/pstg_pkg.sv
package pstg_pkg;

   localparam int MAX_STATES = 16;

   localparam int RATIO_W    = 5;
   localparam int VID_W      = 6;
   localparam int CID_W      = RATIO_W + 1;
   localparam int SPAN_W     = CID_W + 1;
   localparam int CNT_W      = $clog2(MAX_STATES + 1);
   localparam int IDX_W      = 6;
   localparam int FID_W      = 8;
   localparam int FREQ_W     = 16;
   localparam int MV_W       = 11;
   localparam int FSB_W      = 10;
   localparam int FAM_W      = 3;
   localparam int STAT_W     = 2;
   localparam int DQ_W       = VID_W + 2;
   localparam int DIV_CNT_W  = $clog2(DQ_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = FSB_W;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_DISABLED = 2'd1;
   localparam logic [STAT_W-1:0] ST_INVERTED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_FAMILY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOBILE_PART  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FSB_MHZ      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_RATIO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC_FSB  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PSTATE_EN    = 3'd5;

   // core families
   localparam logic [FAM_W-1:0] FAM_PENTIUM_M   = 3'd0;
   localparam logic [FAM_W-1:0] FAM_NETBURST_OLD = 3'd1;
   localparam logic [FAM_W-1:0] FAM_NETBURST_NEW = 3'd2;
   localparam logic [FAM_W-1:0] FAM_CORE        = 3'd3;
   localparam logic [FAM_W-1:0] FAM_CORE45      = 3'd4;
   localparam logic [FAM_W-1:0] FAM_ATOM        = 3'd5;
   localparam logic [FAM_W-1:0] FAM_I7          = 3'd6;
   localparam logic [FAM_W-1:0] FAM_I5          = 3'd7;

   localparam logic [FID_W-1:0] FID_DBUS_BIT = 8'h80;
   localparam logic [FID_W-1:0] FID_HALF_BIT = 8'h40;
   localparam logic [RATIO_W-1:0] DBUS_RATIO_LIMIT = 5'h06;

   typedef struct packed {
      logic [FAM_W-1:0] core_family;
      logic             mobile_part;
      logic [FSB_W-1:0] fsb_mhz;
      logic             half_ratio_enable;
      logic             dynamic_fsb_enable;
      logic             pstate_enable;
   } cfg_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [CID_W-1:0]  top;
      logic [CNT_W-1:0]  count;
      logic [VID_W-1:0]  max_vid;
      logic [VID_W-1:0]  min_vid;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]  state_index;
      logic [FID_W-1:0]  fid_code;
      logic [VID_W-1:0]  vid_code;
      logic [FREQ_W-1:0] frequency_mhz;
      logic [MV_W-1:0]   voltage_mv;
      logic              last;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

// File: src/pstg_front.sv
module pstg_front
   import pstg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_push,
   output logic               req_full,
   input  logic [RATIO_W-1:0] req_max_ratio,
   input  logic [VID_W-1:0]   req_max_vid,
   input  logic [RATIO_W-1:0] req_min_ratio,
   input  logic [VID_W-1:0]   req_min_vid,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  logic               cmd_pop
);

   logic [RATIO_W-1:0] low_ratio;
   logic [CID_W-1:0]   top;
   logic [CID_W-1:0]   bottom;
   logic [SPAN_W-1:0]  span_cnt;
   cmd_type            new_cmd;

   cmd_type    ent_ff [2];
   cmd_type    ent_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   always_comb begin
      // zero min ratio without bus halving falls back to the max ratio
      if (req_min_ratio == '0 && !cfg.dynamic_fsb_enable) begin
         low_ratio = req_max_ratio;
      end else begin
         low_ratio = req_min_ratio;
      end
      top      = {req_max_ratio, cfg.half_ratio_enable};
      bottom   = cfg.dynamic_fsb_enable ? {1'b0, low_ratio} : {low_ratio, 1'b0};
      span_cnt = {1'b0, top - bottom} + SPAN_W'(1);

      new_cmd.top     = top;
      new_cmd.max_vid = req_max_vid;
      new_cmd.min_vid = req_min_vid;
      if (span_cnt > SPAN_W'(MAX_STATES)) begin
         new_cmd.count = CNT_W'(MAX_STATES);
      end else begin
         new_cmd.count = CNT_W'(span_cnt);
      end
      priority if (top < bottom) begin
         new_cmd.status = ST_INVERTED;
      end else if (!cfg.pstate_enable) begin
         new_cmd.status = ST_DISABLED;
      end else begin
         new_cmd.status = ST_OK;
      end
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = ent_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      ent_in    = ent_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         ent_in[wr_ptr_ff] = new_cmd;
         wr_ptr_in         = !wr_ptr_ff;
      end
      if (pop_ok) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: src/pstg_div.sv
module pstg_div
   import pstg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DQ_W-1:0]  dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [DQ_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DQ_W-1:0]      q_ff, q_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W:0]       shifted;
   logic [CNT_W:0]       diff;
   logic                 fits;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, q_ff[DQ_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = !diff[CNT_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[DQ_W-2:0], fits};
         rem_in = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: src/pstg_rsp_queue.sv
module pstg_rsp_queue
   import pstg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type item,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   rsp_type    ent_ff [2];
   rsp_type    ent_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head    = ent_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      ent_in    = ent_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         ent_in[wr_ptr_ff] = item;
         wr_ptr_in         = !wr_ptr_ff;
      end
      if (pop_ok) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: src/pstg_back.sv
module pstg_back
   import pstg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp_item,
   input  logic    rsp_full
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;
   localparam logic [2:0] S_ERR  = 3'd4;

   function automatic logic [FREQ_W-1:0] freq_of(logic [FID_W-1:0] fid,
                                                  logic [FSB_W-1:0] fsb);
      logic [FSB_W:0]    halfbus;
      logic [FREQ_W-1:0] prod;
      logic [FREQ_W-1:0] sum;
      halfbus = ({1'b0, fsb} + (FSB_W+1)'(1)) >> 1;
      prod    = FREQ_W'(fid[RATIO_W-1:0]) * FREQ_W'(fsb);
      sum     = prod + (fid[6] ? FREQ_W'(halfbus) : '0);
      return fid[7] ? (sum >> 1) : sum;
   endfunction

   function automatic logic [MV_W-1:0] volt_of(logic [VID_W-1:0] v,
                                                logic [FAM_W-1:0] fam,
                                                logic mobile);
      logic [12:0] lo;
      logic [12:0] acc;
      lo  = 13'(v[4:0]);
      acc = '0;
      unique case (fam)
         FAM_PENTIUM_M: begin
            acc = 13'd700 + 13'({v, 4'b0});
         end
         FAM_NETBURST_OLD, FAM_NETBURST_NEW: begin
            if (lo <= 13'h15) begin
               acc = 13'd2150 + lo * 13'd50;
            end else begin
               acc = 13'd600 + lo * 13'd50;
            end
            acc = (acc + (v[5] ? 13'd25 : 13'd0)) >> 1;
         end
         FAM_CORE: begin
            acc = ((mobile ? 13'd1425 : 13'd1650) + 13'(v) * 13'd25) >> 1;
         end
         FAM_CORE45, FAM_ATOM: begin
            acc = (13'd1425 + 13'(v) * 13'd25) >> 1;
         end
         FAM_I7, FAM_I5: begin
            acc = (13'd6450 - 13'(v) * 13'd25) >> 2;
         end
         default: begin
            acc = '0;
         end
      endcase
      return MV_W'(acc);
   endfunction

   logic [2:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [DQ_W-1:0]  step_ff, step_in;
   logic [DQ_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0] u_ff, u_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [FID_W-1:0] pend_fid_ff, pend_fid_in;
   logic [VID_W-1:0] pend_vid_ff, pend_vid_in;

   logic [CID_W-1:0]   cid;
   logic [RATIO_W-1:0] ratio;
   logic [FID_W-1:0]   fid;
   logic               keep;
   logic               emit;
   logic               u_end;
   logic               div_start;
   logic               div_done;
   logic [DQ_W-1:0]    div_quot;
   logic [DQ_W-1:0]    div_dividend;
   logic [CNT_W-1:0]   div_divisor;

   pstg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign div_dividend = {cmd.max_vid - cmd.min_vid, 2'b00};
   assign div_divisor  = cmd.count - CNT_W'(1);

   always_comb begin
      cid   = cmd_ff.top - CID_W'(u_ff);
      ratio = cid[CID_W-1:1];
      if (ratio < DBUS_RATIO_LIMIT) begin
         fid = cfg.dynamic_fsb_enable ? (FID_DBUS_BIT | {2'b00, ratio, 1'b0})
                                      : {3'b000, ratio};
      end else if (cfg.half_ratio_enable) begin
         fid = {3'b000, ratio} | (cid[0] ? FID_HALF_BIT : '0);
      end else begin
         fid = {3'b000, ratio};
      end
      // a repeat of the fid just kept is dropped
      keep  = !pend_valid_ff || (fid != pend_fid_ff);
      emit  = keep && pend_valid_ff;
      u_end = (u_ff == cmd_ff.count - CNT_W'(1));
   end

   always_comb begin
      rsp_item.state_index   = n_ff;
      rsp_item.fid_code      = pend_fid_ff;
      rsp_item.vid_code      = pend_vid_ff;
      rsp_item.frequency_mhz = freq_of(pend_fid_ff, cfg.fsb_mhz);
      rsp_item.voltage_mv    = volt_of(pend_vid_ff, cfg.core_family, cfg.mobile_part);
      rsp_item.last          = (state_ff == S_LAST);
      rsp_item.status        = ST_OK;
      if (state_ff == S_ERR) begin
         rsp_item               = '0;
         rsp_item.last          = 1'b1;
         rsp_item.status        = cmd_ff.status;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      u_in          = u_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_fid_in   = pend_fid_ff;
      pend_vid_in   = pend_vid_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd;
               acc_in        = {cmd.max_vid, 2'b00};
               u_in          = '0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               step_in       = '0;
               if (cmd.status != ST_OK) begin
                  state_in = S_ERR;
               end else if (cmd.count > CNT_W'(1) && cmd.max_vid >= cmd.min_vid) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               step_in  = div_quot;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // the kept state goes out once its successor is known
            if (!(emit && rsp_full)) begin
               rsp_push = emit;
               u_in     = u_ff + CNT_W'(1);
               acc_in   = acc_ff - step_ff;
               if (keep) begin
                  pend_valid_in = 1'b1;
                  pend_fid_in   = fid;
                  pend_vid_in   = acc_ff[DQ_W-1:2];
               end
               if (emit) begin
                  n_in = n_ff + IDX_W'(1);
               end
               if (u_end) begin
                  state_in = S_LAST;
               end
            end
         end
         S_LAST, S_ERR: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      u_ff        <= u_in;
      n_ff        <= n_in;
      pend_fid_ff <= pend_fid_in;
      pend_vid_ff <= pend_vid_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

// File: src/pstate_table_generator.sv
// channel   direction  handshake                     beat
// req_      in         push & !full                  max_ratio, max_vid, min_ratio, min_vid
// rsp_      out        pop & !empty                  one p-state or one error entry
// csr_      in         we                            index, wdata (no read-back)
//
// a request is queued by the front; when count is above one and max_vid >= min_vid the
// divider then works out the vid step; the back walks one ratio step per cycle (at most
// MAX_STATES) while the result queue has room, and then the final entry; errors skip both.
// the back handles one request at a time; up to two requests and two results queue.
// reset is synchronous, active high, and restores the register defaults.
// results stall only when the result queue is full; requests stall when the command
// queue is full.
module pstate_table_generator
   import pstg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [RATIO_W-1:0]    req_max_ratio,
   input  logic [VID_W-1:0]      req_max_vid,
   input  logic [RATIO_W-1:0]    req_min_ratio,
   input  logic [VID_W-1:0]      req_min_vid,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [IDX_W-1:0]      rsp_state_index,
   output logic [FID_W-1:0]      rsp_fid_code,
   output logic [VID_W-1:0]      rsp_vid_code,
   output logic [FREQ_W-1:0]     rsp_frequency_mhz,
   output logic [MV_W-1:0]       rsp_voltage_mv,
   output logic                  rsp_last,
   output logic [STAT_W-1:0]     rsp_status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    rsp_push;
   rsp_type rsp_item;
   logic    rsp_full;
   rsp_type rsp_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CORE_FAMILY: cfg_in.core_family        = csr_wdata[FAM_W-1:0];
            CSR_MOBILE_PART: cfg_in.mobile_part        = csr_wdata[0];
            CSR_FSB_MHZ:     cfg_in.fsb_mhz            = csr_wdata[FSB_W-1:0];
            CSR_HALF_RATIO:  cfg_in.half_ratio_enable  = csr_wdata[0];
            CSR_DYNAMIC_FSB: cfg_in.dynamic_fsb_enable = csr_wdata[0];
            CSR_PSTATE_EN:   cfg_in.pstate_enable      = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.core_family        <= FAM_CORE;
         cfg_ff.mobile_part        <= 1'b0;
         cfg_ff.fsb_mhz            <= FSB_W'(200);
         cfg_ff.half_ratio_enable  <= 1'b0;
         cfg_ff.dynamic_fsb_enable <= 1'b0;
         cfg_ff.pstate_enable      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pstg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_max_ratio (req_max_ratio),
      .req_max_vid   (req_max_vid),
      .req_min_ratio (req_min_ratio),
      .req_min_vid   (req_min_vid),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   pstg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item),
      .rsp_full  (rsp_full)
   );

   pstg_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .item  (rsp_item),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .head  (rsp_head)
   );

   assign rsp_state_index   = rsp_head.state_index;
   assign rsp_fid_code      = rsp_head.fid_code;
   assign rsp_vid_code      = rsp_head.vid_code;
   assign rsp_frequency_mhz = rsp_head.frequency_mhz;
   assign rsp_voltage_mv    = rsp_head.voltage_mv;
   assign rsp_last          = rsp_head.last;
   assign rsp_status        = rsp_head.status;

   a_cmd_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty queue");

   a_rsp_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> (rsp_last && rsp_fid_code == '0))
      else $error("error entry is not a lone zero entry");

endmodule
